[sv/ovlsd_pkg.sv]
// Package for the ordered value list: sizes, operation and status codes,
// controller states and the command struct between controller and datapath.
// No dependencies.
`default_nettype none

package ovlsd_pkg;

    localparam int CAPACITY    = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int CNT_W       = $clog2(CAPACITY + 1);

    // Byte-padded width of the result word: found, status, entry_count.
    localparam int RES_BITS    = 1 + 2 + CNT_W;
    localparam int RES_W       = ((RES_BITS + 7) / 8) * 8;

    typedef enum logic [1:0] {
        OP_ADD_FRONT = 2'd0,
        OP_ADD_BACK  = 2'd1,
        OP_SEARCH    = 2'd2,
        OP_DELETE    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STAT_DONE   = 2'd0,
        STAT_FULL   = 2'd1,
        STAT_ABSENT = 2'd2
    } t_status;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic load;  // capture the incoming operation and value
        logic exec;  // apply the captured operation and fill the result register
    } t_dp_cmd;

endpackage

`default_nettype wire

[sv/ovlsd_ctrl.sv]
// Controller of the ordered value list: handshake state machine and the
// output valid flag. Depends on ovlsd_pkg.
`default_nettype none

module ovlsd_ctrl
    import ovlsd_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire logic    i_out_ready,
    output logic         o_in_ready,
    output logic         o_out_valid,
    output t_dp_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_load;
    logic   w_exec;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Outputs and commands.
    always_comb begin
        w_load = 1'b0;
        w_exec = 1'b0;
        case (r_state)
            ST_IDLE: begin
                w_load = i_in_valid;
            end
            ST_EXEC: begin
                w_exec = !r_out_valid || i_out_ready;
            end
            default: begin
                w_load = 1'b0;
            end
        endcase
        o_in_ready  = (r_state == ST_IDLE);
        o_cmd.load  = w_load;
        o_cmd.exec  = w_exec;
        o_out_valid = r_out_valid;
    end

    // The result register fills on exec and empties when its transfer completes.
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_exec) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

[sv/ovlsd_datapath.sv]
// Datapath of the ordered value list: a row of value cells that compare in
// parallel and shift as a group, the count and the result register.
// Depends on ovlsd_pkg.
`default_nettype none

module ovlsd_datapath
    import ovlsd_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_dp_cmd                 i_cmd,
    input  wire logic [1:0]              i_operation,
    input  wire logic [VALUE_WIDTH-1:0]  i_value,
    output logic                         o_found,
    output logic [1:0]                   o_status,
    output logic [CNT_W-1:0]             o_entry_count
);

    logic [VALUE_WIDTH-1:0] r_cell [CAPACITY];
    logic [VALUE_WIDTH-1:0] n_cell [CAPACITY];
    logic [CNT_W-1:0]       r_cnt;
    logic [CNT_W-1:0]       n_cnt;
    t_op                    r_op;
    logic [VALUE_WIDTH-1:0] r_value;
    logic                   r_found;
    t_status                r_status;
    logic [CNT_W-1:0]       r_out_cnt;

    logic [CAPACITY-1:0]    w_match;
    logic [CAPACITY-1:0]    w_from;   // cell sits at or behind the first match
    logic                   w_hit;
    logic                   w_full;
    t_status                w_status;

    // Per-cell compare against the held value, live cells only.
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            w_match[i] = (CNT_W'(i) < r_cnt) && (r_cell[i] == r_value);
        end
        for (int i = 0; i < CAPACITY; i++) begin
            w_from[i] = |(w_match & ({CAPACITY{1'b1}} >> (CAPACITY - 1 - i)));
        end
        w_hit  = |w_match;
        w_full = (r_cnt == CNT_W'(CAPACITY));
    end

    always_comb begin
        n_cell   = r_cell;
        n_cnt    = r_cnt;
        w_status = STAT_DONE;
        case (r_op)
            OP_ADD_FRONT: begin
                if (w_full) begin
                    w_status = STAT_FULL;
                end else begin
                    n_cell[0] = r_value;
                    for (int i = 1; i < CAPACITY; i++) begin
                        n_cell[i] = r_cell[i-1];
                    end
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            OP_ADD_BACK: begin
                if (w_full) begin
                    w_status = STAT_FULL;
                end else begin
                    for (int i = 0; i < CAPACITY; i++) begin
                        if (r_cnt == CNT_W'(i)) begin
                            n_cell[i] = r_value;
                        end
                    end
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            OP_SEARCH: begin
                if (!w_hit) begin
                    w_status = STAT_ABSENT;
                end
            end
            OP_DELETE: begin
                if (!w_hit) begin
                    w_status = STAT_ABSENT;
                end else begin
                    // Cells from the first match onward pull from their neighbor.
                    for (int i = 0; i < CAPACITY - 1; i++) begin
                        if (w_from[i]) begin
                            n_cell[i] = r_cell[i+1];
                        end
                    end
                    n_cnt = r_cnt - CNT_W'(1);
                end
            end
            default: begin
                w_status = STAT_DONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= t_op'(i_operation);
            r_value <= i_value;
        end
        if (i_cmd.exec) begin
            r_cell    <= n_cell;
            r_found   <= w_hit && ((r_op == OP_SEARCH) || (r_op == OP_DELETE));
            r_status  <= w_status;
            r_out_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.exec) begin
            r_cnt <= n_cnt;
        end
    end

    assign o_found       = r_found;
    assign o_status      = r_status;
    assign o_entry_count = r_out_cnt;

endmodule

`default_nettype wire

[sv/ordered_value_list_search_delete.sv]
// Top level of the ordered value list with search and delete.
// Instantiates ovlsd_ctrl and ovlsd_datapath; depends on ovlsd_pkg.
//
//   Channel   Dir  Signals                  Contents
//   s_axis    in   tvalid tready tdata tuser tdata: value; tuser: operation
//   m_axis    out  tvalid tready tdata       tdata: found, status, entry_count
//
// Each item is first transferred in, then executed: the cell row compares
// all live values in parallel and shifts or writes as needed. The input side
// is not ready while the item executes.
// The result waits in an output register, so a new item is taken while the
// previous result is still pending; execute stalls only if that register
// is still full. Reset (synchronous, active low) empties the list and the
// output register; stored values are not cleared since cells beyond the
// count are never read.
`default_nettype none

module ordered_value_list_search_delete
    import ovlsd_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // Input item stream.
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  wire logic [VALUE_WIDTH-1:0] i_s_axis_tdata,  // [31:0] value
    input  wire logic [1:0]             i_s_axis_tuser,  // [1:0] operation
    // Result stream.
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    output logic [RES_W-1:0]            o_m_axis_tdata   // [0] found, [2:1] status,
                                                         // [7:3] entry_count
);

    t_dp_cmd          w_cmd;
    logic             w_found;
    logic [1:0]       w_status;
    logic [CNT_W-1:0] w_entry_count;

    // The controller owns the handshakes; the datapath only follows commands.
    ovlsd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_cmd       (w_cmd)
    );

    ovlsd_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_operation   (i_s_axis_tuser),
        .i_value       (i_s_axis_tdata),
        .o_found       (w_found),
        .o_status      (w_status),
        .o_entry_count (w_entry_count)
    );

    // Pack the result with found in the lowest bit, zero-filled to a byte.
    assign o_m_axis_tdata = RES_W'({w_entry_count, w_status, w_found});

endmodule

`default_nettype wire

[sv/ovlsd_checker.sv]
// Port-level checker for the ordered value list and its bind to the top level.
// Depends on ovlsd_pkg.
`default_nettype none

module ovlsd_checker
    import ovlsd_pkg::*;
(
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   i_s_axis_tvalid,
    input wire logic                   o_s_axis_tready,
    input wire logic [VALUE_WIDTH-1:0] i_s_axis_tdata,
    input wire logic [1:0]             i_s_axis_tuser,
    input wire logic                   o_m_axis_tvalid,
    input wire logic                   i_m_axis_tready,
    input wire logic [RES_W-1:0]       o_m_axis_tdata
);

    logic             w_found;
    logic [1:0]       w_status;
    logic [CNT_W-1:0] w_cnt;
    logic             w_in_xfer;

    assign w_found   = o_m_axis_tdata[0];
    assign w_status  = o_m_axis_tdata[2:1];
    assign w_cnt     = o_m_axis_tdata[RES_BITS-1:3];
    assign w_in_xfer = i_s_axis_tvalid && o_s_axis_tready;

    // A pending result holds until its transfer completes.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result changed or dropped while stalled");

    // The input side closes for the execute cycle after every transfer.
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> !o_s_axis_tready)
        else $error("input accepted during execute");

    // A found result always reports done status.
    a_found_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && w_found |-> w_status == STAT_DONE)
        else $error("found with non-done status");

    // A dropped add only happens on a full list, and the count never exceeds capacity.
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (w_cnt <= CNT_W'(CAPACITY))
            && (w_status != STAT_FULL || w_cnt == CNT_W'(CAPACITY)))
        else $error("count out of range or full status below capacity");

    // Status never carries the unused code.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> w_status == STAT_DONE || w_status == STAT_FULL
            || w_status == STAT_ABSENT)
        else $error("invalid status code");

endmodule

bind ordered_value_list_search_delete ovlsd_checker u_ovlsd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

`default_nettype wire
